### sv/rpst_pkg.sv
// Shared constants, codes and types of the random pick set table.
// No dependencies; compile first.
package rpst_pkg;

  // Store geometry
  localparam int unsigned CAPACITY    = 64;
  localparam int unsigned IDX_W       = $clog2(CAPACITY);
  localparam int unsigned CNT_W       = $clog2(CAPACITY + 1);

  // Field widths
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned DRAW_W      = 31;
  localparam int unsigned BIT_W       = $clog2(DRAW_W);
  localparam int unsigned ACTION_W    = 2;
  localparam int unsigned COUNT_OUT_W = 7;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_PICK   = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_MISS  = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  // Operands of the shared subtract/compare unit
  typedef struct packed {
    logic [DATA_W-1:0] op_a;
    logic [DATA_W-1:0] op_b;
  } alu_req_t;

  typedef struct packed {
    logic              eq;
    logic              ge;
    logic [DATA_W-1:0] diff;
  } alu_rsp_t;

  // Store write and read port controls
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
  } ram_ctl_t;

endpackage

### sv/rpst_if.sv
// Valid/ready channel interfaces for request and response beats.
// Depends on rpst_pkg.
interface rpst_in_if;
  import rpst_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [ACTION_W-1:0]      action;
  logic signed [DATA_W-1:0] value;
  logic [DRAW_W-1:0]        random_draw;

  modport source (output valid, action, value, random_draw, input ready);
  modport sink   (input valid, action, value, random_draw, output ready);
endinterface

interface rpst_out_if;
  import rpst_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic signed [DATA_W-1:0] picked;
  logic [COUNT_OUT_W-1:0]   element_count;

  modport source (output valid, status, picked, element_count, input ready);
  modport sink   (input valid, status, picked, element_count, output ready);
endinterface

### sv/rpst_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rpst_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/rpst_alu.sv
// Shared subtract/compare unit: equality for the slot scan, trial
// subtraction for the remainder steps. Depends on rpst_pkg.
module rpst_alu (
  input  rpst_pkg::alu_req_t req_i,
  output rpst_pkg::alu_rsp_t rsp_o
);
  import rpst_pkg::*;

  logic [DATA_W:0] diff_full;

  // One wide subtract; borrow out gives the compare
  assign diff_full  = {1'b0, req_i.op_a} - {1'b0, req_i.op_b};
  assign rsp_o.diff = diff_full[DATA_W-1:0];
  assign rsp_o.ge   = ~diff_full[DATA_W];
  assign rsp_o.eq   = (diff_full[DATA_W-1:0] == '0);

endmodule

### sv/rpst_ctrl.sv
// Sequencer and datapath registers: slot scan, move-last-on-remove and
// restoring remainder for pick. Depends on rpst_pkg, rpst_if, rpst_alu.
module rpst_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  rpst_in_if.sink             in_i,
  rpst_out_if.source          out_o,
  output rpst_pkg::ram_ctl_t  ram_ctl_o,
  input  logic [rpst_pkg::DATA_W-1:0] ram_rdata_i
);
  import rpst_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SEARCH = 7'b0000010,
    S_MOVE   = 7'b0000100,
    S_DIV    = 7'b0001000,
    S_PREAD  = 7'b0010000,
    S_PDATA  = 7'b0100000,
    S_RESP   = 7'b1000000
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  ptr_q, ptr_d;
  logic [BIT_W-1:0]  bit_q, bit_d;
  logic [ACTION_W-1:0] act_q, act_d;
  logic [DATA_W-1:0] val_q, val_d;
  logic [DRAW_W-1:0] draw_q, draw_d;
  logic [IDX_W-1:0]  slot_q, slot_d;
  logic [IDX_W-1:0]  rem_q, rem_d;
  status_e           status_q, status_d;
  logic [DATA_W-1:0] picked_q, picked_d;

  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;
  logic [IDX_W:0]    trial;
  logic              scan_end;
  logic              hit;

  rpst_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  // Partial remainder with the next draw bit shifted in
  assign trial    = {rem_q, draw_q[DRAW_W-1]};
  assign scan_end = (ptr_q >= cnt_q);
  assign hit      = !scan_end && alu_rsp.eq;

  // Route operands to the shared unit
  always_comb begin
    if (state_q == S_DIV) begin
      alu_req.op_a = DATA_W'(trial);
      alu_req.op_b = DATA_W'(cnt_q);
    end else begin
      alu_req.op_a = ram_rdata_i;
      alu_req.op_b = val_q;
    end
  end

  // Sequencer
  always_comb begin
    state_d         = state_q;
    cnt_d           = cnt_q;
    ptr_d           = ptr_q;
    bit_d           = bit_q;
    act_d           = act_q;
    val_d           = val_q;
    draw_d          = draw_q;
    slot_d          = slot_q;
    rem_d           = rem_q;
    status_d        = status_q;
    picked_d        = picked_q;
    ram_ctl_o.we    = 1'b0;
    ram_ctl_o.waddr = IDX_W'(cnt_q);
    ram_ctl_o.wdata = val_q;
    ram_ctl_o.raddr = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          act_d    = in_i.action;
          val_d    = in_i.value;
          draw_d   = in_i.random_draw;
          status_d = ST_DONE;
          picked_d = '0;
          ptr_d    = '0;
          unique case (in_i.action)
            ACT_INSERT, ACT_REMOVE: begin
              state_d = S_SEARCH;
            end
            ACT_PICK: begin
              if (cnt_q == '0) begin
                status_d = ST_EMPTY;
                state_d  = S_RESP;
              end else begin
                rem_d   = '0;
                bit_d   = BIT_W'(DRAW_W - 1);
                state_d = S_DIV;
              end
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end

      S_SEARCH: begin
        ram_ctl_o.raddr = IDX_W'(ptr_q + 1'b1);
        if (scan_end) begin
          if (act_q == ACT_INSERT) begin
            if (cnt_q == CNT_W'(CAPACITY)) begin
              status_d = ST_FULL;
            end else begin
              ram_ctl_o.we = 1'b1;
              cnt_d        = cnt_q + 1'b1;
            end
          end else begin
            status_d = ST_MISS;
          end
          state_d = S_RESP;
        end else if (hit) begin
          if (act_q == ACT_INSERT) begin
            status_d = ST_MISS;
            state_d  = S_RESP;
          end else begin
            // Fetch the last element to fill the hole
            slot_d          = IDX_W'(ptr_q);
            ram_ctl_o.raddr = IDX_W'(cnt_q - 1'b1);
            state_d         = S_MOVE;
          end
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end

      S_MOVE: begin
        ram_ctl_o.we    = 1'b1;
        ram_ctl_o.waddr = slot_q;
        ram_ctl_o.wdata = ram_rdata_i;
        cnt_d           = cnt_q - 1'b1;
        state_d         = S_RESP;
      end

      S_DIV: begin
        // Restoring step: keep the difference when the trial fits
        if (alu_rsp.ge) begin
          rem_d = alu_rsp.diff[IDX_W-1:0];
        end else begin
          rem_d = trial[IDX_W-1:0];
        end
        draw_d = draw_q << 1;
        bit_d  = bit_q - 1'b1;
        if (bit_q == '0) begin
          state_d = S_PREAD;
        end
      end

      S_PREAD: begin
        ram_ctl_o.raddr = rem_q;
        state_d         = S_PDATA;
      end

      S_PDATA: begin
        picked_d = ram_rdata_i;
        state_d  = S_RESP;
      end

      S_RESP: begin
        if (out_o.ready) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ptr_q   <= '0;
      bit_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ptr_q   <= ptr_d;
      bit_q   <= bit_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    act_q    <= act_d;
    val_q    <= val_d;
    draw_q   <= draw_d;
    slot_q   <= slot_d;
    rem_q    <= rem_d;
    status_q <= status_d;
    picked_q <= picked_d;
  end

  // Channel drive
  assign in_i.ready          = (state_q == S_IDLE);
  assign out_o.valid         = (state_q == S_RESP);
  assign out_o.status        = status_q;
  assign out_o.picked        = $signed(picked_q);
  assign out_o.element_count = COUNT_OUT_W'(cnt_q);

endmodule

### sv/random_pick_set_table.sv
// Channel   Dir  Beat contents                          Handshake
// in_i      in   action, value, random_draw             valid/ready
// out_o     out  status, picked, element_count          valid/ready
//
// One request at a time; ready is low from acceptance until the response
// beat is taken. Insert and remove scan one slot per cycle through the
// shared compare unit; a remove hit ends the scan and then moves the last
// element into the hole. Pick runs 31 restoring remainder steps followed
// by a store read of the picked slot (S_PREAD, S_PDATA).
// Unused action codes go straight to the response state.
// Reset clears the count and sequencer; store contents need no clearing.
// A stalled response holds the block until out_o.ready.
// Depends on rpst_pkg, rpst_if, rpst_ram, rpst_ctrl.
module random_pick_set_table (
  input  logic       clk_i,
  input  logic       rst_ni,
  rpst_in_if.sink    in_i,
  rpst_out_if.source out_o
);
  import rpst_pkg::*;

  ram_ctl_t          ram_ctl;
  logic [DATA_W-1:0] ram_rdata;

  rpst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .ram_ctl_o   (ram_ctl),
    .ram_rdata_i (ram_rdata)
  );

  // Element store
  rpst_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_ctl.we),
    .waddr_i (ram_ctl.waddr),
    .wdata_i (ram_ctl.wdata),
    .raddr_i (ram_ctl.raddr),
    .rdata_o (ram_rdata)
  );

`ifndef SYNTH
  // Never take a request while a response is pending
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid))
    else $error("request accepted while response pending");

  // Store writes only happen inside a request
  a_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_ctl.we |-> !in_i.ready)
    else $error("store written while idle");

  // Empty-set pick reports zero element and zero count
  a_empty_pick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status == ST_EMPTY) |->
      (out_o.picked == '0 && out_o.element_count == '0))
    else $error("empty pick with nonzero payload");

  // Count never passes capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (int'(out_o.element_count) <= int'(CAPACITY)))
    else $error("element count above capacity");
`endif

endmodule
